@@ rtl/core/isotp_pkg.sv @@
// shared types and constants for the iso-tp segmentation engine
package isotp_pkg;

	typedef enum logic [3:0] {
		ST_OK       = 4'd0,
		ST_BUSY     = 4'd1,
		ST_INVFRAME = 4'd2,
		ST_MSGREADY = 4'd3,
		ST_RXOVF    = 4'd4,
		ST_FRAME    = 4'd5,
		ST_UNEXP    = 4'd6,
		ST_TIMEOUT  = 4'd7,
		ST_SEQ      = 4'd8,
		ST_WAIT     = 4'd9,
		ST_WAITLIM  = 4'd10,
		ST_REMOVF   = 4'd11,
		ST_INVARG   = 4'd12,
		ST_TOOBIG   = 4'd13
	} status_t;

	typedef enum logic [2:0] {
		FN_FRAME   = 3'd0,
		FN_TICK    = 3'd1,
		FN_LOAD    = 3'd2,
		FN_START   = 3'd3,
		FN_READ    = 3'd4,
		FN_RELEASE = 3'd5,
		FN_CANCRX  = 3'd6,
		FN_CANCTX  = 3'd7
	} func_t;

	typedef enum logic [1:0] {
		RXP_IDLE = 2'd0,
		RXP_RECV = 2'd1,
		RXP_DONE = 2'd2
	} rx_phase_t;

	typedef enum logic [1:0] {
		TXP_IDLE   = 2'd0,
		TXP_WAITFC = 2'd1,
		TXP_SENDCF = 2'd2,
		TXP_DONE   = 2'd3
	} tx_phase_t;

	localparam logic [2:0] CFG_RX_BS   = 3'd0;
	localparam logic [2:0] CFG_RX_STM  = 3'd1;
	localparam logic [2:0] CFG_MAXWAIT = 3'd2;
	localparam logic [2:0] CFG_FC_TO   = 3'd3;
	localparam logic [2:0] CFG_CF_TO   = 3'd4;
	localparam logic [2:0] CFG_RX_CAP  = 3'd5;
	localparam logic [2:0] CFG_TX_CAP  = 3'd6;

	localparam int IN_W  = 3 + 64 + 4 + 32 + 12 + 8 + 12;
	localparam int IN_TW = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W  = 4 + 1 + 64 + 8 + 1 + 12 + 1;
	localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

	// wrap-safe deadline check
	function automatic logic reached(input logic [31:0] now, input logic [31:0] dl);
		logic [31:0] d;
		begin
			d = now - dl;
			reached = !d[31];
		end
	endfunction

endpackage

@@ rtl/core/isotp_segmentation_engine_core.sv @@
// iso-tp transport engine over classic can with byte stores in sync memories
//
// channel   dir  tdata fields (lsb first)
// s_axis    in   func, frame_bytes, frame_len, now_time, buf_index, buf_value, tx_msg_length
// m_axis    out  status, send_valid, send_bytes, rx_byte, message_ready, message_length, tx_done
// cfg       in   cfg_we, cfg_index, cfg_wdata
//
// one item at a time; bytes move through the byte memory port:
// one memory access per cycle, up to seven payload bytes per frame
// reset clears all protocol phases and counters; store contents stay undefined
// the next item is taken once the result is in the output register or has left
module isotp_segmentation_engine_core #(
	parameter int BUFFER_DEPTH = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// func, frame_bytes, frame_len, now_time, buf_index, buf_value, tx_msg_length
	input  logic [isotp_pkg::IN_TW-1:0] s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// status, send_valid, send_bytes, rx_byte, message_ready, message_length, tx_done
	output logic [isotp_pkg::OUT_TW-1:0] m_axis_tdata,
	input  logic                        cfg_we,
	input  logic [2:0]                  cfg_index,
	input  logic [30:0]                 cfg_wdata
);
	import isotp_pkg::*;

	localparam int AW = $clog2(BUFFER_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE, S_DECODE, S_RDTX, S_WRRX, S_RDRX, S_FIN, S_OUT
	} state_t;

	state_t state_q;

	// registers
	logic [7:0]  rx_bs_q, rx_stm_q, maxwait_q;
	logic [30:0] fc_to_q, cf_to_q;
	logic [11:0] rx_cap_q, tx_cap_q;

	// protocol state
	rx_phase_t   rx_phase_q;
	logic [11:0] rx_total_q, rx_filled_q;
	logic [31:0] rx_deadline_q;
	logic [3:0]  rx_seq_q;
	logic [7:0]  rx_seen_q;
	tx_phase_t   tx_phase_q;
	logic [11:0] tx_total_q, tx_sent_q;
	logic [31:0] tx_deadline_q;
	logic [16:0] tx_gap_q;
	logic [3:0]  tx_seq_q;
	logic [7:0]  tx_left_q, tx_waits_q;

	// item
	logic [2:0]  func_q;
	logic [63:0] frame_q;
	logic [3:0]  dlc_q;
	logic [31:0] now_q;
	logic [11:0] idx_q, len_q;
	logic [7:0]  val_q;

	// byte copy loop
	logic [2:0]  cnt_q, num_q;     // current byte, bytes to move
	logic [11:0] base_q;           // memory address of first byte
	logic [2:0]  slot_q;           // frame byte slot of first byte
	logic        rd_pend_q;
	logic [2:0]  rd_slot_q;

	// result
	logic [3:0]  st_q;
	logic        sv_q;
	logic [63:0] snd_q;
	logic [7:0]  rb_q;
	logic [OUT_TW-1:0] out_q;
	logic        out_v_q;

	logic [7:0] rx_mem [BUFFER_DEPTH];
	logic [7:0] tx_mem [BUFFER_DEPTH];
	logic [7:0] rx_rd, tx_rd;
	logic       rx_we, tx_we, rx_re, tx_re;
	logic [AW-1:0] rx_wa, tx_wa, rx_ra, tx_ra;
	logic [7:0] rx_wd, tx_wd;

	always_ff @(posedge clk) begin
		if (rx_we) rx_mem[rx_wa] <= rx_wd;
		if (rx_re) rx_rd <= rx_mem[rx_ra];
	end
	always_ff @(posedge clk) begin
		if (tx_we) tx_mem[tx_wa] <= tx_wd;
		if (tx_re) tx_rd <= tx_mem[tx_ra];
	end

	logic [7:0] pci;
	logic [11:0] rx_capv, tx_capv, addr, rx_left, tx_left_b;
	logic [2:0] rx_n, tx_n;
	logic [11:0] fflen;
	logic [7:0] stcode;
	logic [16:0] gap_ms, gap_us;
	logic [12:0] slotsum;
	logic in_rng;

	always_comb begin
		pci     = frame_q[7:0];
		rx_capv = (13'(rx_cap_q) < 13'(BUFFER_DEPTH)) ? rx_cap_q : 12'(BUFFER_DEPTH);
		tx_capv = (13'(tx_cap_q) < 13'(BUFFER_DEPTH)) ? tx_cap_q : 12'(BUFFER_DEPTH);
		rx_left = rx_total_q - rx_filled_q;
		rx_n    = (rx_left > 12'd7) ? 3'd7 : rx_left[2:0];
		tx_left_b = tx_total_q - tx_sent_q;
		tx_n    = (tx_left_b > 12'd7) ? 3'd7 : tx_left_b[2:0];
		fflen   = {pci[3:0], frame_q[15:8]};
		stcode  = frame_q[23:16];
		gap_ms  = 17'(stcode[6:0]) * 17'd1000;
		gap_us  = 17'(stcode - 8'hF0) * 17'd100;
		addr    = base_q + 12'(cnt_q);
		slotsum = 13'(base_q) + 13'(cnt_q);
		in_rng  = slotsum < 13'(BUFFER_DEPTH);
	end

	// memory port control
	always_comb begin
		rx_we = 1'b0; rx_re = 1'b0; tx_we = 1'b0; tx_re = 1'b0;
		rx_wa = addr[AW-1:0]; rx_ra = idx_q[AW-1:0];
		tx_wa = idx_q[AW-1:0]; tx_ra = addr[AW-1:0];
		rx_wd = frame_q[8*(slot_q+cnt_q) +: 8];
		tx_wd = val_q;
		case (state_q)
			S_DECODE: begin
				if (func_q == FN_LOAD && tx_phase_q != TXP_WAITFC &&
				    tx_phase_q != TXP_SENDCF && 13'(idx_q) < 13'(BUFFER_DEPTH))
					tx_we = 1'b1;
			end
			S_WRRX: rx_we = (cnt_q < num_q) && in_rng;
			S_RDTX: tx_re = (cnt_q < num_q) && in_rng;
			S_RDRX: rx_re = 1'b1;
			default: ;
		endcase
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_v_q <= 1'b0;
			rx_bs_q <= 8'd0; rx_stm_q <= 8'd0; maxwait_q <= 8'd0;
			fc_to_q <= 31'd1000000; cf_to_q <= 31'd1000000;
			rx_cap_q <= 12'd4095; tx_cap_q <= 12'd4095;
			rx_phase_q <= RXP_IDLE; rx_total_q <= '0; rx_filled_q <= '0;
			rx_deadline_q <= '0; rx_seq_q <= '0; rx_seen_q <= '0;
			tx_phase_q <= TXP_IDLE; tx_total_q <= '0; tx_sent_q <= '0;
			tx_deadline_q <= '0; tx_gap_q <= '0; tx_seq_q <= '0;
			tx_left_q <= '0; tx_waits_q <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_RX_BS:   rx_bs_q <= cfg_wdata[7:0];
					CFG_RX_STM:  rx_stm_q <= cfg_wdata[7:0];
					CFG_MAXWAIT: maxwait_q <= cfg_wdata[7:0];
					CFG_FC_TO:   fc_to_q <= cfg_wdata;
					CFG_CF_TO:   cf_to_q <= cfg_wdata;
					CFG_RX_CAP:  rx_cap_q <= cfg_wdata[11:0];
					CFG_TX_CAP:  tx_cap_q <= cfg_wdata[11:0];
					default: ;
				endcase
			end
			// in S_FIN the output register is reloaded instead
			if (out_v_q && m_axis_tready && state_q != S_FIN) out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						func_q  <= s_axis_tdata[2:0];
						frame_q <= s_axis_tdata[66:3];
						dlc_q   <= s_axis_tdata[70:67];
						now_q   <= s_axis_tdata[102:71];
						idx_q   <= s_axis_tdata[114:103];
						val_q   <= s_axis_tdata[122:115];
						len_q   <= s_axis_tdata[134:123];
						st_q <= ST_OK; sv_q <= 1'b0; snd_q <= '0; rb_q <= '0;
						cnt_q <= '0; rd_pend_q <= 1'b0;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					state_q <= S_FIN;
					case (func_q)
						FN_FRAME: begin
							if (dlc_q == 4'd0 || dlc_q > 4'd8) st_q <= ST_INVARG;
							else begin
								case (pci[7:4])
									4'h0: begin
										if (rx_phase_q != RXP_IDLE) st_q <= ST_BUSY;
										else if (pci[3:0] == 4'd0 || pci[3:0] > 4'd7 ||
										         12'(pci[3:0]) > rx_capv ||
										         5'(pci[3:0]) + 5'd1 > 5'(dlc_q))
											st_q <= ST_INVFRAME;
										else begin
											base_q <= '0; slot_q <= 3'd1; num_q <= pci[2:0];
											rx_total_q <= 12'(pci[3:0]);
											rx_filled_q <= 12'(pci[3:0]);
											rx_phase_q <= RXP_DONE;
											st_q <= ST_MSGREADY;
											state_q <= S_WRRX;
										end
									end
									4'h1: begin
										if (rx_phase_q != RXP_IDLE) st_q <= ST_BUSY;
										else if (dlc_q != 4'd8 || fflen <= 12'd7)
											st_q <= ST_INVFRAME;
										else if (fflen > rx_capv) begin
											sv_q <= 1'b1; snd_q <= 64'h32; st_q <= ST_RXOVF;
										end else begin
											base_q <= '0; slot_q <= 3'd2; num_q <= 3'd6;
											rx_total_q <= fflen; rx_filled_q <= 12'd6;
											rx_seq_q <= 4'd1; rx_seen_q <= '0;
											rx_deadline_q <= now_q + 32'(cf_to_q);
											rx_phase_q <= RXP_RECV;
											sv_q <= 1'b1;
											snd_q <= {40'd0, rx_stm_q, rx_bs_q, 8'h30};
											st_q <= ST_FRAME;
											state_q <= S_WRRX;
										end
									end
									4'h2: begin
										if (rx_phase_q != RXP_RECV) st_q <= ST_UNEXP;
										else if (reached(now_q, rx_deadline_q)) begin
											rx_phase_q <= RXP_IDLE; rx_total_q <= '0;
											rx_filled_q <= '0; rx_deadline_q <= '0;
											rx_seq_q <= '0; rx_seen_q <= '0;
											st_q <= ST_TIMEOUT;
										end else if (pci[3:0] != rx_seq_q ||
										             dlc_q < 4'd2 || 4'(rx_n) + 4'd1 > dlc_q) begin
											rx_phase_q <= RXP_IDLE; rx_total_q <= '0;
											rx_filled_q <= '0; rx_deadline_q <= '0;
											rx_seq_q <= '0; rx_seen_q <= '0;
											st_q <= (pci[3:0] != rx_seq_q) ? ST_SEQ : ST_INVFRAME;
										end else begin
											base_q <= rx_filled_q; slot_q <= 3'd1; num_q <= rx_n;
											rx_filled_q <= rx_filled_q + 12'(rx_n);
											rx_seq_q <= rx_seq_q + 4'd1;
											state_q <= S_WRRX;
											if (rx_filled_q + 12'(rx_n) == rx_total_q) begin
												rx_phase_q <= RXP_DONE; rx_deadline_q <= '0;
												st_q <= ST_MSGREADY;
											end else begin
												rx_deadline_q <= now_q + 32'(cf_to_q);
												if (rx_bs_q != 8'd0) begin
													if (rx_seen_q + 8'd1 >= rx_bs_q) begin
														rx_seen_q <= '0; sv_q <= 1'b1;
														snd_q <= {40'd0, rx_stm_q, rx_bs_q, 8'h30};
														st_q <= ST_FRAME;
													end else rx_seen_q <= rx_seen_q + 8'd1;
												end
											end
										end
									end
									4'h3: begin
										if (tx_phase_q != TXP_WAITFC) st_q <= ST_UNEXP;
										else if (reached(now_q, tx_deadline_q)) begin
											tx_phase_q <= TXP_IDLE; tx_total_q <= '0; tx_sent_q <= '0;
											tx_deadline_q <= '0; tx_gap_q <= '0; tx_seq_q <= '0;
											tx_left_q <= '0; tx_waits_q <= '0;
											st_q <= ST_TIMEOUT;
										end else if (dlc_q >= 4'd3 && pci[3:0] == 4'd0 &&
										             (stcode <= 8'h7F ||
										              (stcode >= 8'hF1 && stcode <= 8'hF9))) begin
											tx_gap_q <= (stcode <= 8'h7F) ? gap_ms : gap_us;
											tx_left_q <= frame_q[15:8];
											tx_deadline_q <= now_q; tx_waits_q <= '0;
											tx_phase_q <= TXP_SENDCF;
										end else if (dlc_q >= 4'd3 && pci[3:0] == 4'd1 &&
										             tx_waits_q < maxwait_q) begin
											tx_waits_q <= tx_waits_q + 8'd1;
											tx_deadline_q <= now_q + 32'(fc_to_q);
											st_q <= ST_WAIT;
										end else begin
											tx_phase_q <= TXP_IDLE; tx_total_q <= '0; tx_sent_q <= '0;
											tx_deadline_q <= '0; tx_gap_q <= '0; tx_seq_q <= '0;
											tx_left_q <= '0; tx_waits_q <= '0;
											if (dlc_q < 4'd3) st_q <= ST_INVFRAME;
											else if (pci[3:0] == 4'd1) st_q <= ST_WAITLIM;
											else if (pci[3:0] == 4'd2) st_q <= ST_REMOVF;
											else st_q <= ST_INVFRAME;
										end
									end
									default: st_q <= ST_INVFRAME;
								endcase
							end
						end
						FN_TICK: begin
							if (rx_phase_q == RXP_RECV && reached(now_q, rx_deadline_q)) begin
								rx_phase_q <= RXP_IDLE; rx_total_q <= '0;
								rx_filled_q <= '0; rx_deadline_q <= '0;
								rx_seq_q <= '0; rx_seen_q <= '0;
								st_q <= ST_TIMEOUT;
							end else if (tx_phase_q == TXP_WAITFC &&
							             reached(now_q, tx_deadline_q)) begin
								tx_phase_q <= TXP_IDLE; tx_total_q <= '0; tx_sent_q <= '0;
								tx_deadline_q <= '0; tx_gap_q <= '0; tx_seq_q <= '0;
								tx_left_q <= '0; tx_waits_q <= '0;
								st_q <= ST_TIMEOUT;
							end else if (tx_phase_q != TXP_SENDCF ||
							             !reached(now_q, tx_deadline_q)) begin
								st_q <= ST_WAIT;
							end else begin
								sv_q <= 1'b1; snd_q <= {56'd0, 4'h2, tx_seq_q};
								st_q <= ST_FRAME;
								base_q <= tx_sent_q; slot_q <= 3'd1; num_q <= tx_n;
								tx_sent_q <= tx_sent_q + 12'(tx_n);
								tx_seq_q <= tx_seq_q + 4'd1;
								state_q <= S_RDTX;
								if (tx_sent_q + 12'(tx_n) == tx_total_q) begin
									tx_phase_q <= TXP_DONE; tx_deadline_q <= '0;
								end else if (tx_left_q == 8'd1) begin
									tx_left_q <= '0; tx_phase_q <= TXP_WAITFC;
									tx_deadline_q <= now_q + 32'(fc_to_q);
								end else begin
									if (tx_left_q != 8'd0) tx_left_q <= tx_left_q - 8'd1;
									tx_deadline_q <= now_q + 32'(tx_gap_q);
								end
							end
						end
						FN_LOAD: begin
							if (tx_phase_q == TXP_WAITFC || tx_phase_q == TXP_SENDCF)
								st_q <= ST_BUSY;
							else if (13'(idx_q) >= 13'(BUFFER_DEPTH)) st_q <= ST_INVARG;
						end
						FN_START: begin
							if (len_q == 12'd0) st_q <= ST_INVARG;
							else if (len_q > tx_capv) st_q <= ST_TOOBIG;
							else if (tx_phase_q == TXP_WAITFC || tx_phase_q == TXP_SENDCF)
								st_q <= ST_BUSY;
							else begin
								sv_q <= 1'b1; st_q <= ST_FRAME;
								tx_total_q <= len_q; tx_waits_q <= '0;
								base_q <= '0; state_q <= S_RDTX;
								if (len_q <= 12'd7) begin
									snd_q <= {56'd0, 5'd0, len_q[2:0]};
									slot_q <= 3'd1; num_q <= len_q[2:0];
									tx_sent_q <= len_q; tx_phase_q <= TXP_DONE;
								end else begin
									snd_q <= {48'd0, len_q[7:0], 4'h1, len_q[11:8]};
									slot_q <= 3'd2; num_q <= 3'd6;
									tx_sent_q <= 12'd6; tx_seq_q <= 4'd1;
									tx_left_q <= '0; tx_gap_q <= '0;
									tx_deadline_q <= now_q + 32'(fc_to_q);
									tx_phase_q <= TXP_WAITFC;
								end
							end
						end
						FN_READ: begin
							if (rx_phase_q == RXP_DONE && idx_q < rx_total_q &&
							    13'(idx_q) < 13'(BUFFER_DEPTH))
								state_q <= S_RDRX;
							else st_q <= ST_INVARG;
						end
						FN_RELEASE, FN_CANCRX: begin
							if (func_q == FN_CANCRX || rx_phase_q == RXP_DONE) begin
								rx_phase_q <= RXP_IDLE; rx_total_q <= '0;
								rx_filled_q <= '0; rx_deadline_q <= '0;
								rx_seq_q <= '0; rx_seen_q <= '0;
							end
						end
						default: begin
							tx_phase_q <= TXP_IDLE; tx_total_q <= '0; tx_sent_q <= '0;
							tx_deadline_q <= '0; tx_gap_q <= '0; tx_seq_q <= '0;
							tx_left_q <= '0; tx_waits_q <= '0;
						end
					endcase
				end
				S_WRRX: begin
					if (cnt_q + 3'd1 >= num_q || cnt_q >= num_q) state_q <= S_FIN;
					else cnt_q <= cnt_q + 3'd1;
				end
				S_RDTX: begin
					// read issued this cycle lands next cycle
					rd_pend_q <= (cnt_q < num_q) && in_rng;
					rd_slot_q <= slot_q + cnt_q;
					if (rd_pend_q) snd_q[8*rd_slot_q +: 8] <= tx_rd;
					if (cnt_q >= num_q) state_q <= S_FIN;
					else cnt_q <= cnt_q + 3'd1;
				end
				S_RDRX: state_q <= S_OUT;
				S_OUT: begin
					rb_q <= rx_rd;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_v_q || m_axis_tready) begin
						out_q <= OUT_TW'({tx_phase_q == TXP_DONE,
						          (rx_phase_q == RXP_DONE) ? rx_total_q : 12'd0,
						          rx_phase_q == RXP_DONE, rb_q, snd_q, sv_q, st_q});
						out_v_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata)) else $error("out changed");
	a_filled: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_phase_q == RXP_DONE) |-> (rx_filled_q == rx_total_q)) else $error("rx fill");
	a_sent: assert property (@(posedge clk) disable iff (!arst_n)
		(tx_phase_q != TXP_IDLE) |-> (tx_sent_q <= tx_total_q)) else $error("tx sent");
`endif

endmodule
